/* hdl/pcf_pkg.sv */
// Shared types, constants and codes of the palette color-cycle fader.
// Used by every module of the block; depends on nothing else.
package pcf_pkg;

    // Palette and register geometry.
    localparam int PAL_SIZE  = 16;
    localparam int PAL_AW    = $clog2(PAL_SIZE);
    localparam int CNT_W     = 5;
    localparam int LEN_W     = 16 + PAL_AW;
    localparam int PADDR_W   = 5;
    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_AW    = $clog2(OPQ_DEPTH);

    // Fixed values of the fade and blend arithmetic.
    localparam logic [15:0] MIN_PERIOD = 16'd50;
    localparam logic [16:0] FRAC_ONE   = 17'h10000;
    localparam logic [16:0] VIS_THRESH = 17'd655;
    localparam int          FRAC_BITS  = 16;

    // Back pipeline layout: remainder chain, step index, palette read,
    // byte products, byte quotients.
    localparam int NUM_A = 32;
    localparam int SB0   = NUM_A;
    localparam int SC    = SB0 + PAL_AW;
    localparam int SD    = SC + 1;
    localparam int SE0   = SD + 1;
    localparam int NST   = SE0 + 8;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_EVAL  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FM_ZERO = 2'd0,
        FM_ONE  = 2'd1,
        FM_DIV  = 2'd2
    } t_fmode;

    typedef enum logic [2:0] {
        REG_CYCLE_EN = 3'd0,
        REG_PERIOD   = 3'd1,
        REG_COUNT    = 3'd2,
        REG_FADE     = 3'd3,
        REG_DISPLAY  = 3'd4,
        REG_BASE     = 3'd5
    } t_reg;

    // Effective configuration as seen by the datapath.
    typedef struct packed {
        logic              cyc_on;
        logic [15:0]       period;
        logic [CNT_W-1:0]  count;
        logic [LEN_W-1:0]  len;
        logic [15:0]       fade;
        logic [23:0]       display;
        logic [31:0]       base;
    } t_cfg;

    // Classified operation handed from the front to the back.
    typedef struct packed {
        logic              ld;
        logic [31:0]       now;
        logic [PAL_AW-1:0] pidx;
        logic [31:0]       pcol;
        t_fmode            fmode;
        logic [15:0]       fnum;
        logic              expired;
    } t_op;

    // Work record carried down the back pipeline.
    typedef struct packed {
        logic              ld;
        logic [31:0]       nsh;
        logic [PAL_AW-1:0] pidx;
        logic [31:0]       pcol;
        logic [LEN_W-1:0]  rem;
        t_fmode            fmode;
        logic [15:0]       frem;
        logic [15:0]       fquo;
        logic              expired;
        logic [PAL_AW-1:0] idx;
        logic [3:0][23:0]  v;
        logic [3:0][7:0]   q;
    } t_job;

    typedef struct packed {
        logic [31:0] color;
        logic        visible;
        logic        expired;
    } t_res;

endpackage

/* hdl/palette_color_cycle_fade.sv */
// Top level of the palette color-cycle fader: register port, front, queue, back.
// Depends on pcf_pkg, pcf_front, pcf_opq and pcf_back.
//
//   channel   handshake            beat contents
//   input     push / full          i_kind, i_now_ms, i_palette_index, i_palette_color
//   result    empty / pop          o_color_argb, o_visible, o_expired
//   config    psel/penable/pwrite  paddr, pwdata, prdata, pready (always high)
//
// One input beat is taken per cycle while full is low. An evaluation result reaches the
// result queue once it has passed the 32-stage remainder chain and the index, palette
// read, byte product and byte quotient stages, when nothing stalls.
// Reset is synchronous and clears the registers, the active flag and the queues;
// palette contents stay undefined until loaded. When the result queue fills, the
// back pipeline holds, the operation queue fills and full rises.
module palette_color_cycle_fade (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now_ms,
    input  logic [3:0]  i_palette_index,
    input  logic [31:0] i_palette_color,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_color_argb,
    output logic        o_visible,
    output logic        o_expired,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [pcf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pcf_pkg::*;

    logic        r_cyc_en;
    logic [15:0] r_period;
    logic [4:0]  r_count;
    logic [15:0] r_fade;
    logic [23:0] r_display;
    logic [31:0] r_base;
    logic        w_wr;
    t_reg        w_ridx;
    t_cfg        w_cfg;
    logic [15:0] w_period;
    logic [4:0]  w_count;
    logic        w_op_push, w_op_full, w_op_pop, w_op_empty;
    t_op         w_op_in, w_op_out;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_ridx = t_reg'(paddr[4:2]);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyc_en  <= 1'b0;
            r_period  <= MIN_PERIOD;
            r_count   <= '0;
            r_fade    <= '0;
            r_display <= '0;
            r_base    <= '0;
        end else if (w_wr) begin
            case (w_ridx)
                REG_CYCLE_EN: r_cyc_en  <= pwdata[0];
                REG_PERIOD:   r_period  <= pwdata[15:0];
                REG_COUNT:    r_count   <= pwdata[4:0];
                REG_FADE:     r_fade    <= pwdata[15:0];
                REG_DISPLAY:  r_display <= pwdata[23:0];
                REG_BASE:     r_base    <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (w_ridx)
            REG_CYCLE_EN: prdata = {31'd0, r_cyc_en};
            REG_PERIOD:   prdata = {16'd0, r_period};
            REG_COUNT:    prdata = {27'd0, r_count};
            REG_FADE:     prdata = {16'd0, r_fade};
            REG_DISPLAY:  prdata = {8'd0, r_display};
            REG_BASE:     prdata = r_base;
            default:      prdata = '0;
        endcase
    end

    // Effective period and count, and the full cycle length.
    assign w_period = (r_period < MIN_PERIOD) ? MIN_PERIOD : r_period;
    assign w_count  = (r_count > CNT_W'(PAL_SIZE)) ? CNT_W'(PAL_SIZE) : r_count;

    always_comb begin
        w_cfg.cyc_on  = r_cyc_en && (w_count >= 5'd2);
        w_cfg.period  = w_period;
        w_cfg.count   = w_count;
        w_cfg.len     = LEN_W'(LEN_W'(w_period) * LEN_W'(w_count));
        w_cfg.fade    = r_fade;
        w_cfg.display = r_display;
        w_cfg.base    = r_base;
    end

    pcf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_kind          (i_kind),
        .i_now_ms        (i_now_ms),
        .i_palette_index (i_palette_index),
        .i_palette_color (i_palette_color),
        .i_cfg           (w_cfg),
        .o_op_push       (w_op_push),
        .o_op            (w_op_in),
        .i_op_full       (w_op_full)
    );

    pcf_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_op_push),
        .i_data  (w_op_in),
        .o_full  (w_op_full),
        .i_pop   (w_op_pop),
        .o_data  (w_op_out),
        .o_empty (w_op_empty)
    );

    pcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_op         (w_op_out),
        .i_op_empty   (w_op_empty),
        .o_op_pop     (w_op_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_color_argb (o_color_argb),
        .o_visible    (o_visible),
        .o_expired    (o_expired)
    );

    // An evaluation that ends the announcement shows nothing.
    a_expired_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_expired) |-> (!o_visible && o_color_argb[31:24] == 8'd0))
        else $error("expiring result is not dark");

    // The back part only takes from a queue that holds something.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op_pop |-> !w_op_empty)
        else $error("operation queue read while empty");

    // A waiting result stays until it is taken.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result lost");

endmodule

/* hdl/pcf_front.sv */
// Front part: accepts items, keeps start time and active flag, classifies fades.
// Depends on pcf_pkg; feeds pcf_opq.
module pcf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_kind,
    input  logic [31:0]   i_now_ms,
    input  logic [pcf_pkg::PAL_AW-1:0] i_palette_index,
    input  logic [31:0]   i_palette_color,
    input  pcf_pkg::t_cfg i_cfg,
    output logic          o_op_push,
    output pcf_pkg::t_op  o_op,
    input  logic          i_op_full
);
    import pcf_pkg::*;

    logic        r_showing, n_showing;
    logic [31:0] r_start, n_start;
    logic        w_acc;
    logic [31:0] w_d;
    logic        w_neg, w_past;
    logic [23:0] w_left;

    assign o_full = i_op_full;
    assign w_acc  = i_push && !i_op_full;

    // Elapsed time and the checks against the display window.
    assign w_d    = i_now_ms - r_start;
    assign w_neg  = w_d[31];
    assign w_past = !w_neg && (w_d >= {8'd0, i_cfg.display});
    assign w_left = i_cfg.display - w_d[23:0];

    // Operation record and fade class for the back part.
    always_comb begin
        o_op         = '0;
        o_op.ld      = (t_kind'(i_kind) == KIND_LOAD);
        o_op.now     = i_now_ms;
        o_op.pidx    = i_palette_index;
        o_op.pcol    = i_palette_color;
        o_op.expired = r_showing && w_past;
        if (!r_showing || w_neg || w_past) begin
            o_op.fmode = FM_ZERO;
        end else if (w_d[23:0] < {8'd0, i_cfg.fade}) begin
            o_op.fmode = FM_DIV;
            o_op.fnum  = w_d[15:0];
        end else if (w_left < {8'd0, i_cfg.fade}) begin
            o_op.fmode = FM_DIV;
            o_op.fnum  = w_left[15:0];
        end else begin
            o_op.fmode = FM_ONE;
        end
    end

    // Loads and evaluations go on to the back; starts end here.
    always_comb begin
        case (t_kind'(i_kind))
            KIND_LOAD: o_op_push = w_acc;
            KIND_EVAL: o_op_push = w_acc;
            default:   o_op_push = 1'b0;
        endcase
    end

    // Next start time and active flag.
    always_comb begin
        n_start   = r_start;
        n_showing = r_showing;
        if (w_acc) begin
            case (t_kind'(i_kind))
                KIND_START: begin
                    n_start   = i_now_ms;
                    n_showing = 1'b1;
                end
                KIND_EVAL: begin
                    if (r_showing && w_past) begin
                        n_showing = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_showing <= 1'b0;
        end else begin
            r_start   <= n_start;
            r_showing <= n_showing;
        end
    end

endmodule

/* hdl/pcf_opq.sv */
// Short operation queue between the front and back parts.
// Depends on pcf_pkg for the operation record.
module pcf_opq (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  pcf_pkg::t_op i_data,
    output logic         o_full,
    input  logic         i_pop,
    output pcf_pkg::t_op o_data,
    output logic         o_empty
);
    import pcf_pkg::*;

    t_op               r_mem [OPQ_DEPTH];
    logic [OPQ_AW-1:0] r_wp, r_rp;
    logic [OPQ_AW:0]   r_cnt;
    logic              w_wr, w_rd;

    assign o_full  = (r_cnt == (OPQ_AW+1)'(OPQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

endmodule

/* hdl/pcf_back.sv */
// Back part: pipelined remainder chains, palette, byte blend and result queue.
// Depends on pcf_pkg; takes operations from pcf_opq.
module pcf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pcf_pkg::t_cfg i_cfg,
    input  pcf_pkg::t_op  i_op,
    input  logic          i_op_empty,
    output logic          o_op_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [31:0]   o_color_argb,
    output logic          o_visible,
    output logic          o_expired
);
    import pcf_pkg::*;

    t_job              r_pipe [NST];
    t_job              n_pipe [NST];
    logic [NST-1:0]    r_vld, n_vld;
    logic [31:0]       r_pal [PAL_SIZE];
    logic [31:0]       r_c1, r_c2;
    logic              w_adv;
    t_job              w_init;
    logic [CNT_W-1:0]  w_inc;
    logic [PAL_AW-1:0] w_nxt;
    t_res              r_ofifo [2];
    logic              r_owp, r_orp;
    logic [1:0]        r_ocnt;
    logic              w_ofull, w_opush, w_opop;
    t_res              w_res;
    logic [16:0]       w_frac;
    logic [31:0]       w_col;
    logic [24:0]       w_aprod;

    // The whole pipeline holds only when its last result finds the queue full.
    assign w_adv    = !(r_vld[NST-1] && !r_pipe[NST-1].ld && w_ofull);
    assign o_op_pop = w_adv && !i_op_empty;

    // Record entering the first stage.
    always_comb begin
        w_init         = '0;
        w_init.ld      = i_op.ld;
        w_init.nsh     = i_op.now;
        w_init.pidx    = i_op.pidx;
        w_init.pcol    = i_op.pcol;
        w_init.fmode   = i_op.fmode;
        w_init.frem    = i_op.fnum;
        w_init.expired = i_op.expired;
    end

    // One step of work in each stage.
    always_comb begin
        t_job             src;
        t_job             job;
        logic [LEN_W:0]   sh;
        logic [16:0]      f2;
        logic [LEN_W-1:0] psb;
        logic [15:0]      pr;
        logic [23:0]      pse;
        for (int i = 0; i < NST; i++) begin
            if (i == 0) src = w_init;
            else        src = r_pipe[i-1];
            job = src;
            sh  = '0;
            f2  = '0;
            psb = '0;
            pr  = '0;
            pse = '0;
            if (i < SB0) begin
                // Time modulo cycle length, one dividend bit per stage.
                sh = {job.rem, job.nsh[31]};
                if (sh >= {1'b0, i_cfg.len}) job.rem = LEN_W'(sh - {1'b0, i_cfg.len});
                else                         job.rem = sh[LEN_W-1:0];
                job.nsh = {job.nsh[30:0], 1'b0};
                // Fade fraction, one quotient bit per stage.
                if (i < FRAC_BITS) begin
                    f2 = {job.frem, 1'b0};
                    if (f2 >= {1'b0, i_cfg.fade}) begin
                        job.frem = 16'(f2 - {1'b0, i_cfg.fade});
                        job.fquo = {job.fquo[14:0], 1'b1};
                    end else begin
                        job.frem = f2[15:0];
                        job.fquo = {job.fquo[14:0], 1'b0};
                    end
                end
            end else if (i < SC) begin
                // Palette step index and position inside the step.
                psb = LEN_W'(i_cfg.period) << (SC - 1 - i);
                if (job.rem >= psb) begin
                    job.rem = job.rem - psb;
                    job.idx = {job.idx[PAL_AW-2:0], 1'b1};
                end else begin
                    job.idx = {job.idx[PAL_AW-2:0], 1'b0};
                end
            end else if (i == SD) begin
                // Weighted byte sums from the two palette words.
                pr = i_cfg.period - job.rem[15:0];
                for (int b = 0; b < 4; b++) begin
                    job.v[b] = 24'(r_c1[b*8 +: 8]) * 24'(pr)
                             + 24'(r_c2[b*8 +: 8]) * 24'(job.rem[15:0]);
                end
            end else if (i >= SE0) begin
                // Byte quotients by the period, one bit per stage.
                pse = 24'(i_cfg.period) << (NST - 1 - i);
                for (int b = 0; b < 4; b++) begin
                    if (job.v[b] >= pse) begin
                        job.v[b] = job.v[b] - pse;
                        job.q[b] = {job.q[b][6:0], 1'b1};
                    end else begin
                        job.q[b] = {job.q[b][6:0], 1'b0};
                    end
                end
            end
            n_pipe[i] = job;
        end
    end

    always_comb begin
        n_vld[0] = o_op_pop;
        for (int i = 1; i < NST; i++) n_vld[i] = r_vld[i-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NST; i++) r_pipe[i] <= n_pipe[i];
        end
    end

    // Neighbor entry wraps at the palette count.
    assign w_inc = CNT_W'(r_pipe[SC-1].idx) + 1'b1;
    assign w_nxt = (w_inc == i_cfg.count) ? '0 : w_inc[PAL_AW-1:0];

    // Palette: loads write and evaluations read at the same stage, in order.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_vld[SC-1] && r_pipe[SC-1].ld) begin
                r_pal[r_pipe[SC-1].pidx] <= r_pipe[SC-1].pcol;
            end
            r_c1 <= r_pal[r_pipe[SC-1].idx];
            r_c2 <= r_pal[w_nxt];
        end
    end

    // Final color, alpha scaling and flags.
    always_comb begin
        case (r_pipe[NST-1].fmode)
            FM_ONE:  w_frac = FRAC_ONE;
            FM_DIV:  w_frac = {1'b0, r_pipe[NST-1].fquo};
            default: w_frac = '0;
        endcase
        w_col   = i_cfg.cyc_on ? r_pipe[NST-1].q : i_cfg.base;
        w_aprod = 25'(w_col[31:24]) * 25'(w_frac);
        w_res.color[23:0]  = w_col[23:0];
        w_res.color[31:24] = (w_aprod[24:16] > 9'd255) ? 8'hFF : w_aprod[23:16];
        w_res.visible      = (w_frac > VIS_THRESH);
        w_res.expired      = r_pipe[NST-1].expired;
    end

    // Two-entry result queue.
    assign w_ofull = (r_ocnt == 2'd2);
    assign o_empty = (r_ocnt == 2'd0);
    assign w_opush = w_adv && r_vld[NST-1] && !r_pipe[NST-1].ld;
    assign w_opop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (w_opush) r_owp <= !r_owp;
            if (w_opop)  r_orp <= !r_orp;
            case ({w_opush, w_opop})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_opush) r_ofifo[r_owp] <= w_res;
    end

    assign o_color_argb = r_ofifo[r_orp].color;
    assign o_visible    = r_ofifo[r_orp].visible;
    assign o_expired    = r_ofifo[r_orp].expired;

endmodule
